@@ rtl/dqc_pkg.sv @@
// Shared types and constants for the double-ended queue core.
`timescale 1ns / 1ps
package dqc_pkg;

	localparam int OP_W     = 2;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 5;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 40;
	// fan-in of one level of the pop readout tree
	localparam int RADIX    = 16;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

	// Operation broadcast to every cell; each flag is set only for a performed transfer.
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} cell_ctl_t;

endpackage

@@ rtl/dqc_cell.sv @@
// One storage cell of the queue chain: holds a word and shifts with its neighbors.
`timescale 1ns / 1ps
module dqc_cell
	import dqc_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int CW    = 5
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [CW-1:0]     count,
	input  logic [WORD_W-1:0] push_value,
	input  logic [WORD_W-1:0] left_data,
	input  logic [WORD_W-1:0] right_data,
	output logic [WORD_W-1:0] data,
	output logic [WORD_W-1:0] leaf
);

	logic [WORD_W-1:0] data_q;
	logic              sel;

	// front sits in cell 0, entries are packed toward low cells
	always_ff @(posedge clk) begin
		priority if (ctl.push_front) begin
			data_q <= left_data;
		end else if (ctl.pop_front) begin
			data_q <= right_data;
		end else if (ctl.push_back && count == CW'(INDEX)) begin
			data_q <= push_value;
		end
	end

	// pick this cell for readout: cell 0 on a front pop, the last held cell on a back pop
	always_comb begin
		if (ctl.pop_front) begin
			sel = (INDEX == 0);
		end else begin
			sel = ctl.pop_back && (count == CW'(INDEX + 1));
		end
	end

	assign data = data_q;
	assign leaf = data_q & {WORD_W{sel}};

endmodule

@@ rtl/dqc_or_tree.sv @@
// Registered OR-reduction tree that gathers the selected cell word.
`timescale 1ns / 1ps
module dqc_or_tree
	import dqc_pkg::*;
#(
	parameter int N = 16,
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] leaf [N],
	input  logic         take,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] result
);

	function automatic int lvl_count(int n, int l);
		int c;
		c = n;
		for (int i = 0; i <= l; i++) begin
			c = (c + RADIX - 1) / RADIX;
		end
		return c;
	endfunction

	function automatic int num_levels(int n);
		int c;
		int lv;
		c  = (n + RADIX - 1) / RADIX;
		lv = 1;
		while (c > 1) begin
			c  = (c + RADIX - 1) / RADIX;
			lv = lv + 1;
		end
		return lv;
	endfunction

	localparam int LV = num_levels(N);
	localparam int N0 = lvl_count(N, 0);

	logic [W-1:0]  lvl_d [LV][N0];
	logic [W-1:0]  lvl_q [LV][N0];
	logic [LV-1:0] vld_d;
	logic [LV-1:0] vld_q;

	for (genvar l = 0; l < LV; l++) begin : g_lvl
		localparam int NI = (l == 0) ? N : lvl_count(N, l - 1);
		localparam int NO = lvl_count(N, l);
		for (genvar g = 0; g < NO; g++) begin : g_grp
			if (l == 0) begin : g_leaf
				always_comb begin
					lvl_d[l][g] = '0;
					for (int k = 0; k < RADIX; k++) begin
						if (g * RADIX + k < NI) begin
							lvl_d[l][g] = lvl_d[l][g] | leaf[g * RADIX + k];
						end
					end
				end
				always_ff @(posedge clk) begin
					if (in_valid) begin
						lvl_q[l][g] <= lvl_d[l][g];
					end
				end
			end else begin : g_node
				always_comb begin
					lvl_d[l][g] = '0;
					for (int k = 0; k < RADIX; k++) begin
						if (g * RADIX + k < NI) begin
							lvl_d[l][g] = lvl_d[l][g] | lvl_q[l-1][g * RADIX + k];
						end
					end
				end
				always_ff @(posedge clk) begin
					if (vld_q[l-1]) begin
						lvl_q[l][g] <= lvl_d[l][g];
					end
				end
			end
		end
	end

	// the last level holds its word until the consumer takes it
	always_comb begin
		for (int l = 0; l < LV; l++) begin
			vld_d[l] = (l == 0) ? in_valid : vld_q[(l == 0) ? 0 : l - 1];
			if (l == LV - 1) begin
				vld_d[l] = vld_d[l] | (vld_q[l] & ~take);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= vld_d;
		end
	end

	if (LV > 1) begin : g_busy
		assign busy = |vld_q[LV-2:0];
	end else begin : g_nobusy
		assign busy = 1'b0;
	end

	assign done   = vld_q[LV-1];
	assign result = lvl_q[LV-1][0];

endmodule

@@ rtl/double_ended_queue_core.sv @@
// Top level of the double-ended queue: cell chain, count control and result register.
// An item's result is offered after its transfer has passed the readout tree levels
// and then the output register.
// The readout tree holds one item at a time; a new item is taken once the tree is empty
// or in the cycle its predecessor moves into the output register.
// Reset clears the entry count and the handshake state; cell contents are left as is.
`timescale 1ns / 1ps
module double_ended_queue_core
	import dqc_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // op[1:0], push_value[33:2], zero fill[39:34]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // pop_value[31:0], status[33:32], entry_count[38:34], is_empty[39]
);

	localparam int CW = $clog2(DEPTH + 1);

	op_t               op;
	logic [WORD_W-1:0] push_value;
	logic              accept;
	logic              is_full;
	logic              is_zero;
	cell_ctl_t         ctl;
	status_t           status_d;
	logic [CW-1:0]     count_d;
	logic [CW-1:0]     count_q;

	logic [WORD_W-1:0] data_w [DEPTH];
	logic [WORD_W-1:0] leaf_w [DEPTH];

	logic              tree_busy;
	logic              tree_done;
	logic [WORD_W-1:0] tree_word;
	logic              take;

	status_t           status_q;
	logic              pop_ok_q;
	logic [CW-1:0]     count_res_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;
	logic [WORD_W-1:0] pop_value_d;

	assign op         = op_t'(s_tdata[OP_W-1:0]);
	assign push_value = s_tdata[OP_W +: WORD_W];
	assign is_full    = (count_q == CW'(DEPTH));
	assign is_zero    = (count_q == '0);
	assign take       = tree_done && (!m_tvalid_q || m_tready);
	assign s_tready   = !tree_busy && (!tree_done || take);
	assign accept     = s_tvalid && s_tready;

	always_comb begin
		ctl      = '0;
		status_d = ST_OK;
		count_d  = count_q;
		unique case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					ctl.push_front = accept && (op == OP_PUSH_FRONT);
					ctl.push_back  = accept && (op == OP_PUSH_BACK);
					count_d        = count_q + CW'(1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (is_zero) begin
					status_d = ST_EMPTY;
				end else begin
					ctl.pop_front = accept && (op == OP_POP_FRONT);
					ctl.pop_back  = accept && (op == OP_POP_BACK);
					count_d       = count_q - CW'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dqc_cell #(
			.INDEX(i),
			.CW   (CW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.push_value(push_value),
			.left_data ((i == 0) ? push_value : data_w[(i == 0) ? 0 : i - 1]),
			.right_data((i == DEPTH - 1) ? data_w[i] : data_w[(i == DEPTH - 1) ? i : i + 1]),
			.data      (data_w[i]),
			.leaf      (leaf_w[i])
		);
	end

	dqc_or_tree #(
		.N(DEPTH),
		.W(WORD_W)
	) u_tree (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(accept),
		.leaf    (leaf_w),
		.take    (take),
		.busy    (tree_busy),
		.done    (tree_done),
		.result  (tree_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// hold the item's side results until the readout word arrives
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			pop_ok_q    <= (status_d == ST_OK) && (op == OP_POP_FRONT || op == OP_POP_BACK);
			count_res_q <= count_d;
		end
	end

	always_comb begin
		if (pop_ok_q) begin
			pop_value_d = tree_word;
		end else if (status_q == ST_EMPTY) begin
			pop_value_d = EMPTY_WORD;
		end else begin
			pop_value_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			m_tvalid_q <= take || (m_tvalid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata_q <= {(count_res_q == '0), ENTRY_W'(count_res_q), status_q, pop_value_d};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) |=> $stable(count_q))
		else $error("refused push changed the count");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("push did not advance the count");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[33:32] == ST_EMPTY)
		|-> (m_tdata[31:0] == EMPTY_WORD) && m_tdata[39])
		else $error("empty pop result malformed");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		tree_busy |-> !s_tready)
		else $error("input taken while readout in flight");

endmodule

@@ verif/tb_double_ended_queue_core.sv @@
// Self-checking testbench for the double-ended queue core.
`timescale 1ns / 1ps
module tb_double_ended_queue_core;
	import dqc_pkg::*;

	localparam int DEQUE_DEPTH = 16;
	localparam int RANDOM_OPS  = 1500;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 250;

	// s_tdata layout, lowest bits last in the list
	typedef struct packed {
		logic [5:0]        fill;
		logic [WORD_W-1:0] push_value;
		op_t               op;
	} deque_cmd_t;

	// m_tdata layout, lowest bits last in the list
	typedef struct packed {
		logic               is_empty;
		logic [ENTRY_W-1:0] entry_count;
		status_t            status;
		logic [WORD_W-1:0]  pop_value;
	} deque_result_t;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	deque_cmd_t      cmd_pending[$];
	deque_result_t   expected_results[$];
	logic [WORD_W-1:0] deque_words[$];

	int accepted_cnt  = 0;
	int cycle_cnt     = 0;
	int hold_left     = 0;
	bit hold_done     = 1'b0;
	int fail_cnt      = 0;
	int mismatch_cnt  = 0;
	int push_cnt      = 0;
	int pop_cnt       = 0;
	int full_cnt      = 0;
	int empty_pop_cnt = 0;
	int peak_fill     = 0;
	logic steady;

	double_ended_queue_core #(.DEPTH(DEQUE_DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// no idling on either side while this window of transfers passes
	assign steady = (accepted_cnt >= 700) && (accepted_cnt < 1000);

	function automatic deque_result_t apply_deque_op(deque_cmd_t c);
		deque_result_t r;
		r.pop_value = '0;
		r.status    = ST_OK;
		case (c.op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (deque_words.size() >= DEQUE_DEPTH) begin
					r.status = ST_FULL;
					full_cnt++;
				end else begin
					if (c.op == OP_PUSH_FRONT)
						deque_words.push_front(c.push_value);
					else
						deque_words.push_back(c.push_value);
					push_cnt++;
				end
			end
			default: begin
				if (deque_words.size() == 0) begin
					r.pop_value = EMPTY_WORD;
					r.status    = ST_EMPTY;
					empty_pop_cnt++;
				end else begin
					if (c.op == OP_POP_FRONT)
						r.pop_value = deque_words.pop_front();
					else
						r.pop_value = deque_words.pop_back();
					pop_cnt++;
				end
			end
		endcase
		r.entry_count = ENTRY_W'(deque_words.size());
		r.is_empty    = (deque_words.size() == 0);
		if (deque_words.size() > peak_fill)
			peak_fill = deque_words.size();
		return r;
	endfunction

	task automatic check_result(input logic [OUT_W-1:0] raw);
		deque_result_t got;
		deque_result_t want;
		got = raw;
		if (expected_results.size() == 0) begin
			fail_cnt++;
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("[%0t] unexpected result %h", $realtime, raw);
		end else begin
			want = expected_results.pop_front();
			if (got.pop_value !== want.pop_value || got.status !== want.status ||
			    got.entry_count !== want.entry_count || got.is_empty !== want.is_empty) begin
				fail_cnt++;
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("[%0t] mismatch: value %h/%h status %0d/%0d count %0d/%0d empty %b/%b (exp/act)",
						$realtime, want.pop_value, got.pop_value, want.status, got.status,
						want.entry_count, got.entry_count, want.is_empty, got.is_empty);
			end
		end
	endtask

	task automatic add_cmd(input op_t op, input logic [WORD_W-1:0] value);
		deque_cmd_t c;
		c.fill       = '0;
		c.op         = op;
		c.push_value = value;
		cmd_pending.push_back(c);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// driver: advance to the next pending item after each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (cmd_pending.size() != 0 && (steady || $urandom_range(99) >= 38)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= cmd_pending.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted_cnt >= 300) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= 38);
	end

	// monitor: check outgoing transfers, then predict incoming ones
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_deque_op(deque_cmd_t'(s_tdata)));
				accepted_cnt <= accepted_cnt + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("double_ended_queue_core verification failed");
			$finish;
		end
	end

	initial begin
		int n;
		int run_len;
		int push_pct;
		int k;

		// empty pops from both ends
		add_cmd(OP_POP_FRONT, 32'h1234_5678);
		add_cmd(OP_POP_BACK, 32'hFFFF_FFFF);
		// extreme words at both ends
		add_cmd(OP_PUSH_BACK, 32'h8000_0000);
		add_cmd(OP_PUSH_BACK, 32'h7FFF_FFFF);
		add_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFF);
		add_cmd(OP_PUSH_FRONT, 32'h0000_0000);
		// fill up to the bound, then push into a full queue
		for (k = 0; k < 12; k++)
			add_cmd(k[0] ? OP_PUSH_FRONT : OP_PUSH_BACK,
				k[1] ? 32'hAAAA_AAAA ^ k : 32'h5555_5555 ^ k);
		add_cmd(OP_PUSH_FRONT, 32'hDEAD_0001);
		add_cmd(OP_PUSH_BACK, 32'hDEAD_0002);
		add_cmd(OP_POP_FRONT, 32'h0);
		add_cmd(OP_POP_BACK, 32'h0);
		add_cmd(OP_POP_BACK, 32'hFFFF_FFFF);

		// random walk in runs with changing push bias, reaching both bounds
		n = 0;
		while (n < RANDOM_OPS) begin
			run_len = $urandom_range(60, 8);
			case ($urandom_range(3))
				0: push_pct = 15;
				1: push_pct = 50;
				2: push_pct = 85;
				default: push_pct = 95;
			endcase
			for (k = 0; k < run_len && n < RANDOM_OPS; k++) begin
				if ($urandom_range(99) < push_pct)
					add_cmd($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_word());
				else
					add_cmd($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, pick_word());
				n++;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_pending.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		fail_cnt += expected_results.size();

		$display("%0d transfers: %0d pushes, %0d pops, %0d refused on full, %0d pops on empty",
			accepted_cnt, push_cnt, pop_cnt, full_cnt, empty_pop_cnt);
		$display("peak occupancy %0d of %0d, %0d mismatches", peak_fill, DEQUE_DEPTH,
			mismatch_cnt);
		if (fail_cnt == 0)
			$display("double_ended_queue_core verification clean");
		else
			$display("double_ended_queue_core verification failed");
		$finish;
	end

endmodule
